// File: src/ede_pkg.sv
`timescale 1ns / 1ps
package ede_pkg;

  localparam int DIST_W      = 16;
  localparam int BYTE_W      = 8;
  localparam int ACT_W       = 2;
  localparam int MAX_REF_DEF = 64;

  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FINISH = 2'd2;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // One wavefront token moving down the row of cells.
  typedef struct packed {
    logic              valid;
    logic              fin;     // finish token: reports and clears
    logic              ovf;     // overflow flag captured at acceptance
    logic [BYTE_W-1:0] qbyte;
    logic [DIST_W-1:0] val;     // new value of the cell to the left
    logic [DIST_W-1:0] diag;    // old value of the cell to the left
    logic [DIST_W-1:0] res;     // distance, latched at the last reference cell
    logic [DIST_W-1:0] idx;     // reference length for this token
  } tok_t;

  function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
    return (v == DIST_MAX) ? DIST_MAX : v + 1'b1;
  endfunction

  function automatic logic [DIST_W-1:0] min3(input logic [DIST_W-1:0] a,
                                             input logic [DIST_W-1:0] b,
                                             input logic [DIST_W-1:0] c);
    logic [DIST_W-1:0] m;
    m = (a < b) ? a : b;
    return (c < m) ? c : m;
  endfunction

endpackage

// File: src/edit_distance_engine.sv
`timescale 1ns / 1ps
// Channel  Handshake           Payload
// in       in_valid/in_stall   action, data_byte
// out      out_valid/out_stall distance, final_res, ref_overflow
//
// Query and finish transactions enter one per cycle unless the output is valid and stalled,
// and ripple through a head stage plus MAX_REF_LEN cells; each result leaves the last cell.
// An append waits until no query or finish transaction is still in the chain.
// The whole chain holds while the output is valid and stalled.
// rst is synchronous; it restores every row cell to its index and empties the chain.
module edit_distance_engine import ede_pkg::*; #(
  parameter int MAX_REF_LEN = MAX_REF_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ACT_W-1:0]  action,
  input  logic [BYTE_W-1:0] data_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DIST_W-1:0] distance,
  output logic              final_res,
  output logic              ref_overflow
);

  localparam int LEN_W = $clog2(MAX_REF_LEN + 1);
  localparam int CNT_W = $clog2(MAX_REF_LEN + 3);

  tok_t chain [0:MAX_REF_LEN];

  logic              adv;
  logic              busy;
  logic              acc;
  logic              enter;
  logic              app_wr;
  logic [LEN_W-1:0]  len;
  logic [DIST_W-1:0] qlen;
  logic              ovf;
  logic [CNT_W-1:0]  cnt;
  logic              take;
  tok_t              head;
  tok_t              head_next;

  assign adv      = !(out_valid && out_stall);
  assign busy     = (cnt != '0);
  assign in_stall = !adv || ((action == ACT_APPEND) && busy);
  assign acc      = in_valid && !in_stall;
  assign enter    = acc && ((action == ACT_QUERY) || (action == ACT_FINISH));
  assign app_wr   = acc && (action == ACT_APPEND) && (qlen == '0) &&
                    (len != LEN_W'(MAX_REF_LEN));
  assign take     = out_valid && !out_stall;

  always_comb begin
    head_next       = '0;
    head_next.valid = enter;
    head_next.fin   = (action == ACT_FINISH);
    head_next.ovf   = ovf;
    head_next.qbyte = data_byte;
    head_next.idx   = DIST_W'(len);
    head_next.diag  = qlen;
    head_next.val   = (action == ACT_FINISH) ? qlen : sat_inc(qlen);
    head_next.res   = (len == '0) ? head_next.val : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
      len        <= '0;
      qlen       <= '0;
      ovf        <= 1'b0;
      cnt        <= '0;
    end else begin
      if (adv) begin
        head <= head_next;
      end
      if (acc) begin
        unique case (action)
          ACT_APPEND: begin
            if (qlen == '0) begin
              if (len != LEN_W'(MAX_REF_LEN)) begin
                len <= len + 1'b1;
              end else begin
                ovf <= 1'b1;
              end
            end
          end
          ACT_QUERY: begin
            qlen <= sat_inc(qlen);
          end
          ACT_FINISH: begin
            len  <= '0;
            qlen <= '0;
            ovf  <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (enter && !take) begin
        cnt <= cnt + 1'b1;
      end else if (!enter && take) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign chain[0] = head;

  for (genvar j = 1; j <= MAX_REF_LEN; j++) begin : g_cell
    ede_cell #(
      .J(j)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .wr_en  (app_wr && (len == LEN_W'(j - 1))),
      .wr_byte(data_byte),
      .tok_in (chain[j-1]),
      .tok_out(chain[j])
    );
  end

  assign out_valid    = chain[MAX_REF_LEN].valid;
  assign distance     = chain[MAX_REF_LEN].res;
  assign final_res    = chain[MAX_REF_LEN].fin;
  assign ref_overflow = chain[MAX_REF_LEN].ovf;

endmodule

// File: src/ede_cell.sv
`timescale 1ns / 1ps
module ede_cell import ede_pkg::*; #(
  parameter int J = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              wr_en,
  input  logic [BYTE_W-1:0] wr_byte,
  input  tok_t              tok_in,
  output tok_t              tok_out
);

  localparam logic [DIST_W-1:0] INIT = DIST_W'(J);

  logic [BYTE_W-1:0] chr;
  logic [DIST_W-1:0] row;
  logic [DIST_W-1:0] row_next;
  logic [DIST_W-1:0] pick;
  tok_t              tok_next;

  always_comb begin
    pick = (chr == tok_in.qbyte) ? tok_in.diag
                                 : sat_inc(min3(row, tok_in.val, tok_in.diag));
    tok_next = tok_in;
    row_next = row;
    if (tok_in.valid) begin
      if (tok_in.fin) begin
        row_next      = INIT;
        tok_next.val  = row;
        tok_next.diag = row;
        tok_next.res  = (tok_in.idx == INIT) ? row : tok_in.res;
      end else begin
        row_next      = pick;
        tok_next.val  = pick;
        tok_next.diag = row;
        tok_next.res  = (tok_in.idx == INIT) ? pick : tok_in.res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row           <= INIT;
      tok_out.valid <= 1'b0;
    end else if (adv) begin
      row     <= row_next;
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      chr <= wr_byte;
    end
  end

endmodule
